// ----- sv/wpi_pkg.sv -----
// Shared types and constants for the waypoint path interpolator.
// No dependencies; imported by every module of the block.
package wpi_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int COMP_W            = 32;
  localparam int NCOMP             = 6;    // pos x,y,z then look x,y,z
  localparam int STEP_W            = 23;   // Q7.16 path position
  localparam int FRAC_W            = 16;
  localparam int IDX_W             = STEP_W - FRAC_W;
  localparam int CNT_W             = 7;
  localparam int INC_W             = 16;
  localparam int ENTRY_W           = 6;

  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd1;
  localparam logic [INC_W-1:0] INC_RESET   = 16'd3277;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef logic [COMP_W-1:0]            comp_t;
  typedef logic [NCOMP-1:0][COMP_W-1:0] vec6_t;
  typedef logic [FRAC_W-1:0]            frac_t;

endpackage

// ----- sv/wpi_table.sv -----
// Waypoint table: one write port, one read port with registered read data.
// Each entry holds position and look vectors. Depends on wpi_pkg.
module wpi_table
  import wpi_pkg::*;
#(
  parameter int DEPTH = MAX_WAYPOINTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  vec6_t         wdata,
  input  logic [AW-1:0] raddr,
  output vec6_t         rdata
);

  vec6_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wpi_lerp.sv -----
// Shared lerp datapath: one subtractor, one 33x17 multiplier and one rounding
// adder, pipelined over the six components in turn. Depends on wpi_pkg.
module wpi_lerp
  import wpi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  vec6_t a,
  input  vec6_t b,
  input  frac_t f,
  output logic  done,
  output vec6_t result
);

  localparam logic [2:0] LAST_CNT = 3'(NCOMP + 1);

  logic                 busy;
  logic [2:0]           cnt;
  logic [2:0]           wr_sel;
  logic signed [32:0]   d_reg;
  logic signed [49:0]   prod;
  comp_t                a1;
  comp_t                a2;
  logic signed [49:0]   biased;
  logic signed [33:0]   delta;

  assign wr_sel = cnt - 3'd2;
  assign biased = prod + 50'sd32768;
  assign delta  = 34'(biased >>> FRAC_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST_CNT);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // stage 1: difference, stage 2: product, stage 3: round and add
  always_ff @(posedge clk) begin
    if (busy && cnt < 3'(NCOMP)) begin
      d_reg <= $signed({b[cnt][COMP_W-1], b[cnt]}) - $signed({a[cnt][COMP_W-1], a[cnt]});
      a1    <= a[cnt];
    end
    if (busy && cnt >= 3'd1 && cnt <= 3'(NCOMP)) begin
      prod <= 50'(d_reg * $signed({1'b0, f}));
      a2   <= a1;
    end
    if (busy && cnt >= 3'd2) begin
      result[wr_sel] <= a2 + delta[COMP_W-1:0];
    end
  end

endmodule

// ----- sv/waypoint_path_interpolator.sv -----
// Waypoint path interpolator. A load request (tuser = 0) writes one table entry
// when its index is within the table and returns nothing. An advance request
// (tuser = 1) returns one camera result: two table reads, the shared multiply
// pipeline that serves the six components one after another, the pipeline's
// registered done flag, and the output register. When the step fraction is zero
// the multiply is skipped. The next request can be taken in the same cycle that
// the result appears in the output register. Input is not taken while an advance
// is in flight or its result waits in the output register's path.
// Depends on wpi_pkg, wpi_table and wpi_lerp.
module waypoint_path_interpolator
  import wpi_pkg::*;
#(
  parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [199:0] s_tdata,  // entry_index, in_pos_x/y/z, in_look_x/y/z, zero pad
  input  logic         s_tuser,  // op
  // stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,  // out_pos_x/y/z, out_look_x/y/z
  // config
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = $clog2(MAX_WAYPOINTS);

  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_INC   = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RDA  = 3'd1;
  localparam logic [2:0] ST_RDB  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  waypoint_count;
  logic [INC_W-1:0]  step_increment;
  logic [STEP_W-1:0] path_step;
  logic [IDX_W-1:0]  idx_reg;
  frac_t             f_reg;
  vec6_t             a_reg;

  logic [CNT_W-1:0]  n_eff;
  logic [STEP_W-1:0] last;
  logic [STEP_W-1:0] cur_step;
  logic [STEP_W:0]   step_sum;
  logic              s_req;
  logic              out_load;
  logic              tbl_we;
  logic [AW-1:0]     raddr;
  vec6_t             rdata;
  logic              lerp_start;
  logic              lerp_done;
  vec6_t             lerp_res;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      waypoint_count <= COUNT_RESET;
      step_increment <= INC_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_COUNT: waypoint_count <= pwdata[CNT_W-1:0];
        REG_INC:   step_increment <= pwdata[INC_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_COUNT: prdata = 32'(waypoint_count);
      REG_INC:   prdata = 32'(step_increment);
      default:   prdata = '0;
    endcase
  end

  // effective count and end of path
  always_comb begin
    if (waypoint_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(waypoint_count) > MAX_WAYPOINTS) begin
      n_eff = CNT_W'(MAX_WAYPOINTS);
    end else begin
      n_eff = waypoint_count;
    end
    last     = {n_eff - CNT_W'(1), {FRAC_W{1'b0}}};
    cur_step = (path_step > last) ? '0 : path_step;
    step_sum = {1'b0, path_step} + (STEP_W + 1)'(step_increment);
  end

  assign s_tready   = (state == ST_IDLE);
  assign s_req      = s_tvalid && s_tready;
  assign out_load   = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign tbl_we     = s_req && (s_tuser == OP_LOAD) && (32'(s_tdata[5:0]) < MAX_WAYPOINTS);
  assign raddr      = (state == ST_RDA) ? AW'(idx_reg) : AW'(idx_reg + IDX_W'(1));
  assign lerp_start = (state == ST_RDB) && (f_reg != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      path_step <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_req && s_tuser == OP_ADVANCE) begin
            path_step <= cur_step;
            state     <= ST_RDA;
          end
        end
        ST_RDA: begin
          path_step <= (step_sum > {1'b0, last}) ? '0 : step_sum[STEP_W-1:0];
          state     <= ST_RDB;
        end
        ST_RDB: begin
          state <= (f_reg == '0) ? ST_DONE : ST_MUL;
        end
        ST_MUL: begin
          if (lerp_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_req && s_tuser == OP_ADVANCE) begin
      idx_reg <= cur_step[STEP_W-1:FRAC_W];
      f_reg   <= cur_step[FRAC_W-1:0];
    end
    if (state == ST_RDB) begin
      a_reg <= rdata;
    end
    if (out_load) begin
      m_tdata <= (f_reg == '0) ? a_reg : lerp_res;
    end
  end

  wpi_table #(
    .DEPTH (MAX_WAYPOINTS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(s_tdata[5:0])),
    .wdata (s_tdata[197:6]),
    .raddr (raddr),
    .rdata (rdata)
  );

  wpi_lerp u_lerp (
    .clk    (clk),
    .rst    (rst),
    .start  (lerp_start),
    .a      (a_reg),
    .b      (rdata),
    .f      (f_reg),
    .done   (lerp_done),
    .result (lerp_res)
  );

endmodule
